// ===== hdl/mac_demux_interface_queues_core_defines.svh =====
// Assertion macros used by the receive demux ring engine.
`ifndef MAC_DEMUX_INTERFACE_QUEUES_CORE_DEFINES_SVH
`define MAC_DEMUX_INTERFACE_QUEUES_CORE_DEFINES_SVH

// Invariant that must hold at every clock edge out of reset.
`define MDIQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("invariant violated");

// Consequence checked in the cycle after the trigger.
`define MDIQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

// ===== hdl/mdiq_pkg.sv =====
// Shared types, constants and codes for the receive demux with interface rings.
package mdiq_pkg;

  localparam int MAC_W       = 48;
  localparam int HANDLE_W    = 16;
  localparam int NUM_IF      = 3;
  localparam int IF_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int APB_AW      = 6;
  localparam int APB_DW      = 64;
  localparam int FIFO_DEPTH  = 2;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int MATCH_BYTES_DEF = 6;

  // Source OUI bytes 1 and 2 that mark a frame whose multicast bit was cleared
  localparam logic [7:0] OUI_BYTE1 = 8'h80;
  localparam logic [7:0] OUI_BYTE2 = 8'h0A;
  localparam int         MCAST_BIT = 40;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED = 3'd0,
    ST_FULL   = 3'd1,
    ST_DOWN   = 3'd2,
    ST_TAKEN  = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_OTH1_UC = 3'd0,
    REG_OTH1_BC = 3'd1,
    REG_OTH2_UC = 3'd2,
    REG_OTH2_BC = 3'd3,
    REG_IF_UP   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [MAC_W-1:0]  oth1_uc;
    logic [MAC_W-1:0]  oth1_bc;
    logic [MAC_W-1:0]  oth2_uc;
    logic [MAC_W-1:0]  oth2_bc;
    logic [NUM_IF-1:0] if_up;
  } cfg_t;

  // Classified item handed from the front end to the ring engine
  typedef struct packed {
    logic                take;
    logic [IF_W-1:0]     ring;
    logic                down;
    logic                bad_sel;
    logic [MAC_W-1:0]    src;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage

// ===== hdl/mdiq_cfg.sv =====
// APB register file holding the match addresses and interface up mask.
module mdiq_cfg
  import mdiq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:3]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_OTH1_UC: cfg_d.oth1_uc = pwdata[MAC_W-1:0];
        REG_OTH1_BC: cfg_d.oth1_bc = pwdata[MAC_W-1:0];
        REG_OTH2_UC: cfg_d.oth2_uc = pwdata[MAC_W-1:0];
        REG_OTH2_BC: cfg_d.oth2_bc = pwdata[MAC_W-1:0];
        REG_IF_UP:   cfg_d.if_up   = pwdata[NUM_IF-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OTH1_UC: prdata = APB_DW'(cfg_q.oth1_uc);
      REG_OTH1_BC: prdata = APB_DW'(cfg_q.oth1_bc);
      REG_OTH2_UC: prdata = APB_DW'(cfg_q.oth2_uc);
      REG_OTH2_BC: prdata = APB_DW'(cfg_q.oth2_bc);
      REG_IF_UP:   prdata = APB_DW'(cfg_q.if_up);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/mdiq_front.sv =====
// Front end: restores the multicast bit and picks the target interface ring.
module mdiq_front
  import mdiq_pkg::*;
#(
  parameter int MATCH_BYTES = MATCH_BYTES_DEF
) (
  input  logic                action_i,
  input  logic [MAC_W-1:0]    dest_mac_i,
  input  logic [MAC_W-1:0]    source_mac_i,
  input  logic [HANDLE_W-1:0] buffer_handle_i,
  input  logic [IF_W-1:0]     ring_select_i,
  input  cfg_t                cfg_i,
  output cmd_t                cmd_o
);

  localparam int DROP = MAC_W - 8 * MATCH_BYTES;

  logic [MAC_W-1:0] fixed_src;
  logic             hit2;
  logic             hit1;
  logic [IF_W-1:0]  target;

  // only the leading MATCH_BYTES bytes take part in the compare
  function automatic logic prefix_eq(input logic [MAC_W-1:0] a, input logic [MAC_W-1:0] b);
    prefix_eq = (a >> DROP) == (b >> DROP);
  endfunction

  always_comb begin
    fixed_src = source_mac_i;
    if (source_mac_i[39:32] == OUI_BYTE1 && source_mac_i[31:24] == OUI_BYTE2) begin
      fixed_src[MCAST_BIT] = 1'b1;
    end
  end

  assign hit2 = cfg_i.if_up[2] &&
                (prefix_eq(cfg_i.oth2_uc, dest_mac_i) || prefix_eq(cfg_i.oth2_bc, dest_mac_i));
  assign hit1 = cfg_i.if_up[1] &&
                (prefix_eq(cfg_i.oth1_uc, dest_mac_i) || prefix_eq(cfg_i.oth1_bc, dest_mac_i));
  assign target = hit2 ? IF_W'(2) : (hit1 ? IF_W'(1) : IF_W'(0));

  always_comb begin
    cmd_o        = '0;
    cmd_o.take   = action_i;
    cmd_o.handle = buffer_handle_i;
    if (!action_i) begin
      cmd_o.ring = target;
      cmd_o.down = (target == '0) && !cfg_i.if_up[0];
      cmd_o.src  = fixed_src;
    end else if (ring_select_i == IF_W'(NUM_IF)) begin
      // ring select three names no ring: report empty on interface 0
      cmd_o.bad_sel = 1'b1;
    end else begin
      cmd_o.ring = ring_select_i;
    end
  end

endmodule

// ===== hdl/mdiq_fifo.sv =====
// Short command queue between the front end and the ring engine.
module mdiq_fifo
  import mdiq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          ent_q [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = cnt_q == CW'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mdiq_back.sv =====
// Ring engine: per-interface handle rings, push/pop, and the result register.
`include "mac_demux_interface_queues_core_defines.svh"

module mdiq_back
  import mdiq_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IF_W-1:0]     interface_index_o,
  output logic [MAC_W-1:0]    fixed_source_mac_o,
  output logic [HANDLE_W-1:0] taken_handle_o
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int AW = $clog2(NUM_IF * RING_DEPTH);
  localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int TW = CW + 2;

  logic [SW-1:0] mem_q [NUM_IF * RING_DEPTH];
  logic [SW-1:0] rd_q;

  logic [IW-1:0] head_q [NUM_IF];
  logic [IW-1:0] tail_q [NUM_IF];
  logic [CW-1:0] cnt_q  [NUM_IF];

  logic             out_valid_q;
  status_e          status_q;
  logic [IF_W-1:0]  idx_q;
  logic [MAC_W-1:0] src_q;

  logic [IF_W-1:0] r;
  logic [CW-1:0]   cur_cnt;
  logic [IW-1:0]   cur_head;
  logic [IW-1:0]   cur_tail;
  logic [AW-1:0]   base;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  status_e         res_status;
  logic            do_push;
  logic            do_pop;
  logic            load;
  logic [TW-1:0]   total_cnt;

  assign r        = cmd_i.ring;
  assign cur_cnt  = cnt_q[r];
  assign cur_head = head_q[r];
  assign cur_tail = tail_q[r];
  assign base     = AW'(r) * AW'(RING_DEPTH);
  assign wr_addr  = base + AW'(cur_tail);
  assign rd_addr  = base + AW'(cur_head);

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    res_status = ST_EMPTY;
    if (!cmd_i.take) begin
      if (cmd_i.down) begin
        res_status = ST_DOWN;
      end else if (cur_cnt == CW'(RING_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_QUEUED;
        do_push    = 1'b1;
      end
    end else if (!cmd_i.bad_sel && cur_cnt != '0) begin
      res_status = ST_TAKEN;
      do_pop     = 1'b1;
    end
  end

  assign load      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_IF; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (load) begin
      if (do_push) begin
        tail_q[r] <= (cur_tail == IW'(RING_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
        cnt_q[r]  <= cur_cnt + 1'b1;
      end else if (do_pop) begin
        head_q[r] <= (cur_head == IW'(RING_DEPTH - 1)) ? '0 : cur_head + 1'b1;
        cnt_q[r]  <= cur_cnt - 1'b1;
      end
    end
  end

  // ring storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load && do_push) begin
      mem_q[wr_addr] <= cmd_i.handle[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && do_pop) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= res_status;
      idx_q    <= r;
      src_q    <= cmd_i.src;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign interface_index_o  = idx_q;
  assign fixed_source_mac_o = src_q;
  assign taken_handle_o     = (status_q == ST_TAKEN) ? HANDLE_W'(rd_q) : '0;

  assign total_cnt = TW'(cnt_q[0]) + TW'(cnt_q[1]) + TW'(cnt_q[2]);

  `MDIQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q[0] <= CW'(RING_DEPTH) && cnt_q[1] <= CW'(RING_DEPTH) && cnt_q[2] <= CW'(RING_DEPTH))
  `MDIQ_ASSERT_NEXT(a_push_grows, load && res_status == ST_QUEUED, total_cnt == $past(total_cnt) + 1'b1)
  `MDIQ_ASSERT_NEXT(a_pop_shrinks, load && res_status == ST_TAKEN, total_cnt == $past(total_cnt) - 1'b1)
  `MDIQ_ASSERT_NEXT(a_idle_stable, !load, $stable(total_cnt))

endmodule

// ===== hdl/mac_demux_interface_queues_core.sv =====
// Top level: receive demux over three interfaces with per-interface handle rings.
// An accepted item is written into the command queue, then its result is registered and offered on the output.
// Throughput: one item per cycle while the output is not stalled; each item does at most one access to the ring memory.
// A two-entry command queue lets the input keep accepting while a result is stalled, until the queue is full.
// Reset: all rings and the command queue empty, config registers zero; ring storage needs no clearing pass.
module mac_demux_interface_queues_core
  import mdiq_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int MATCH_BYTES = MATCH_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [MAC_W-1:0]    dest_mac_i,
  input  logic [MAC_W-1:0]    source_mac_i,
  input  logic [HANDLE_W-1:0] buffer_handle_i,
  input  logic [IF_W-1:0]     ring_select_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IF_W-1:0]     interface_index_o,
  output logic [MAC_W-1:0]    fixed_source_mac_o,
  output logic [HANDLE_W-1:0] taken_handle_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;

  mdiq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mdiq_front #(
    .MATCH_BYTES (MATCH_BYTES)
  ) u_front (
    .action_i        (action_i),
    .dest_mac_i      (dest_mac_i),
    .source_mac_i    (source_mac_i),
    .buffer_handle_i (buffer_handle_i),
    .ring_select_i   (ring_select_i),
    .cfg_i           (cfg),
    .cmd_o           (front_cmd)
  );

  mdiq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  assign in_stall_o = q_full;

  mdiq_back #(
    .RING_DEPTH  (RING_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (q_valid),
    .cmd_i              (q_cmd),
    .cmd_pop_o          (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .interface_index_o  (interface_index_o),
    .fixed_source_mac_o (fixed_source_mac_o),
    .taken_handle_o     (taken_handle_o)
  );

endmodule
